FILE: rtl/rsbt_pkg.sv
// ----------------------------------------------------------------------------
// Record stack byte transmitter package
// Shared constants, command and state codes, and the result packing function.
// ----------------------------------------------------------------------------
package rsbt_pkg;

   localparam int RECORD_DEPTH_DEFAULT = 16;
   localparam int REC_BYTES            = 9;
   localparam int REC_W                = REC_BYTES * 8;
   localparam int REQ_DATA_W           = 80;
   localparam int REQ_USER_W           = 3;
   localparam int RSP_DATA_W           = 24;
   localparam int RSP_CNT_W            = 5;
   localparam logic [3:0] POS_LAST     = 4'd9;

   localparam logic [7:0] CHAR_P = 8'h70;
   localparam logic [7:0] CHAR_N = 8'h6e;
   localparam logic [7:0] CHAR_C = 8'h63;
   localparam logic [7:0] CHAR_R = 8'h72;
   localparam logic [7:0] CHAR_A = 8'h61;

   typedef enum logic [2:0] {
      CMD_DATA_PUSH = 3'd0,
      CMD_PART_PUSH = 3'd1,
      CMD_CAL_PUSH  = 3'd2,
      CMD_TX_TICK   = 3'd3,
      CMD_RX_BYTE   = 3'd4
   } cmd_type;

   typedef enum logic {
      ST_IDLE,
      ST_FETCH
   } state_type;

   // Result word, from the lowest bit up.
   function automatic logic [RSP_DATA_W-1:0] pack_rsp(
      input logic                 push_ok,
      input logic                 tx_valid,
      input logic [7:0]           tx_byte,
      input logic                 tx_enabled,
      input logic                 link_ready,
      input logic [RSP_CNT_W-1:0] stored_count
   );
      logic [RSP_DATA_W-1:0] word;
      word = '0;
      word[0]     = push_ok;
      word[1]     = tx_valid;
      word[9:2]   = tx_byte;
      word[10]    = tx_enabled;
      word[11]    = link_ready;
      word[16:12] = stored_count;
      return word;
   endfunction

endpackage

FILE: rtl/record_stack_byte_transmitter.sv
// ----------------------------------------------------------------------------
// Record stack byte transmitter
// Stack of nine-byte records sent out at most one byte per transmit-ready tick.
// ----------------------------------------------------------------------------
// Requests arrive on the req_ channel: req_tuser carries the command and
// req_tdata the nine record bytes and the received byte. Every request
// produces exactly one response on the rsp_ channel.
// Pushes, received bytes and ticks that emit no byte are answered directly:
// the response register is loaded in the cycle the request is accepted.
// A tick that emits a record byte waits in the fetch state, as the top record
// must first be read from the record memory, whose read port is registered.
// The response register decouples the two sides: a new request is taken
// while the previous response is being taken in the same cycle. When the
// receiver stalls, the held response blocks further requests.
// Reset empties the stack, disables transmit, clears the link-ready flag and
// sets the byte position to nine. The record memory needs no clearing pass,
// as only entries below the stack count are ever used and each of those has
// been written by a push. stored_count carries the low five bits of the count.
// ----------------------------------------------------------------------------
module record_stack_byte_transmitter #(
   parameter int RECORD_DEPTH = rsbt_pkg::RECORD_DEPTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // byte_0 .. byte_8, rx_data, eight bits each
   input  logic [rsbt_pkg::REQ_DATA_W-1:0] req_tdata,
   // cmd
   input  logic [rsbt_pkg::REQ_USER_W-1:0] req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // push_ok, tx_valid, tx_byte[7:0], tx_enabled, link_ready, stored_count[4:0]
   output logic [rsbt_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   localparam int ADDR_W = (RECORD_DEPTH > 1) ? $clog2(RECORD_DEPTH) : 1;
   localparam int CNT_W  = $clog2(RECORD_DEPTH + 1);

   rsbt_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [3:0]          pos_ff, pos_in;
   logic                ready_ff, ready_in;
   logic                txen_ff, txen_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [rsbt_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic                      wr_en;
   logic [ADDR_W-1:0]         wr_addr;
   logic [rsbt_pkg::REC_W-1:0] wr_data;
   logic [ADDR_W-1:0]         rd_addr;
   logic [rsbt_pkg::REC_W-1:0] rd_data;

   logic                      req_accept;
   logic                      out_free;
   logic [CNT_W-1:0]          count_dec;
   logic [3:0]                pos_next;
   logic [7:0]                fetch_byte;
   logic                      push_ok;
   logic                      tx_valid;
   logic [7:0]                tx_byte;

   rsbt_ram #(
      .WIDTH (rsbt_pkg::REC_W),
      .DEPTH (RECORD_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == rsbt_pkg::ST_IDLE) && out_free;
   assign req_accept = req_tvalid && req_tready;
   assign count_dec  = count_ff - CNT_W'(1);
   assign pos_next   = (pos_ff == rsbt_pkg::POS_LAST) ? 4'd0 : pos_ff + 4'd1;

   // The read address is the top record; the count does not move while a
   // fetch is outstanding, so the read data is stable in the fetch state.
   assign rd_addr    = count_dec[ADDR_W-1:0];
   assign wr_addr    = count_ff[ADDR_W-1:0];
   assign fetch_byte = rd_data[{pos_ff, 3'b000} +: 8];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rsbt_pkg::ST_IDLE;
         count_ff     <= '0;
         pos_ff       <= rsbt_pkg::POS_LAST;
         ready_ff     <= 1'b0;
         txen_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pos_ff       <= pos_in;
         ready_ff     <= ready_in;
         txen_ff      <= txen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      pos_in       = pos_ff;
      ready_in     = ready_ff;
      txen_in      = txen_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      wr_data      = req_tdata[rsbt_pkg::REC_W-1:0];
      push_ok      = 1'b0;
      tx_valid     = 1'b0;
      tx_byte      = 8'h00;

      unique case (state_ff)
         rsbt_pkg::ST_IDLE: begin
            if (req_accept) begin
               rsp_valid_in = 1'b1;
               unique case (rsbt_pkg::cmd_type'(req_tuser))
                  rsbt_pkg::CMD_DATA_PUSH,
                  rsbt_pkg::CMD_PART_PUSH,
                  rsbt_pkg::CMD_CAL_PUSH: begin
                     if (req_tuser != rsbt_pkg::CMD_DATA_PUSH) begin
                        wr_data = {req_tdata[71:48], 24'h000000,
                                   (req_tuser == rsbt_pkg::CMD_CAL_PUSH) ?
                                      req_tdata[23:16] : 8'h00,
                                   rsbt_pkg::CHAR_N,
                                   (req_tuser == rsbt_pkg::CMD_CAL_PUSH) ?
                                      rsbt_pkg::CHAR_C : rsbt_pkg::CHAR_P};
                     end
                     if (count_ff < CNT_W'(RECORD_DEPTH)) begin
                        wr_en    = 1'b1;
                        count_in = count_ff + CNT_W'(1);
                        txen_in  = 1'b1;
                        push_ok  = 1'b1;
                     end
                  end
                  rsbt_pkg::CMD_TX_TICK: begin
                     if (txen_ff) begin
                        if (count_ff != '0) begin
                           pos_in = pos_next;
                           if (pos_next == rsbt_pkg::POS_LAST) begin
                              count_in = count_dec;
                           end else begin
                              // Byte comes from the store next cycle.
                              rsp_valid_in = 1'b0;
                              state_in     = rsbt_pkg::ST_FETCH;
                           end
                        end else begin
                           txen_in = 1'b0;
                        end
                     end
                  end
                  rsbt_pkg::CMD_RX_BYTE: begin
                     if (req_tdata[79:72] == rsbt_pkg::CHAR_R && !ready_ff) begin
                        ready_in = 1'b1;
                        tx_valid = 1'b1;
                        tx_byte  = rsbt_pkg::CHAR_A;
                     end
                  end
                  default: begin
                  end
               endcase
               rsp_data_in = rsbt_pkg::pack_rsp(push_ok, tx_valid, tx_byte, txen_in,
                                                ready_in,
                                                rsbt_pkg::RSP_CNT_W'(count_in));
            end
         end
         rsbt_pkg::ST_FETCH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = rsbt_pkg::pack_rsp(1'b0, 1'b1, fetch_byte, txen_ff,
                                                 ready_ff,
                                                 rsbt_pkg::RSP_CNT_W'(count_ff));
               state_in     = rsbt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rsbt_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // The stack never holds more records than the store has entries.
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(RECORD_DEPTH))
      else $error("record count beyond store depth");

   // A fetch only starts for a byte position inside a record on a non-empty stack.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == rsbt_pkg::ST_FETCH |-> (pos_ff != rsbt_pkg::POS_LAST && count_ff != '0))
      else $error("fetch with no byte to send");

   // A response without a transmit byte carries a zero byte.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_data_ff[1] |-> rsp_data_ff[9:2] == 8'h00)
      else $error("stray transmit byte");

   // An accepted push on a stack with room grows the stack by one.
   assert property (@(posedge clock) disable iff (reset)
      req_accept && req_tuser <= rsbt_pkg::CMD_CAL_PUSH
         && count_ff < CNT_W'(RECORD_DEPTH)
      |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("push not stored");

   // The record memory is never written while a fetch waits on its read.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == rsbt_pkg::ST_FETCH |-> !wr_en && $stable(count_ff))
      else $error("store modified during fetch");

endmodule

FILE: rtl/rsbt_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module rsbt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
